@@ hdl/gshs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gshs_pkg
// Shared types, constants and the rate limiter for the gated sample and hold.
// ----------------------------------------------------------------------------
package gshs_pkg;

  localparam int CHANNELS    = 16;
  localparam int CH_W        = $clog2(CHANNELS);
  localparam int CHAN_FIELD_W = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int STEP_W      = 16;
  localparam int TICK_W      = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int LIM_W       = (SAMPLE_BITS > STEP_W ? SAMPLE_BITS : STEP_W) + 2;

  localparam logic [CFG_IDX_W-1:0] REG_GATE_ON    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_OFF   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLIDE_DLY  = 2'd2;

  localparam logic signed [CFG_W-1:0] GATE_ON_RST  = 16'sd6400;
  localparam logic signed [CFG_W-1:0] GATE_OFF_RST = 16'sd320;
  localparam logic [TICK_W-1:0]       GLIDE_DLY_RST = 16'd48;

  typedef struct packed {
    logic [CHAN_FIELD_W-1:0]       channel;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic signed [SAMPLE_BITS-1:0] gate_level;
    logic                          gate_button;
    logic [STEP_W-1:0]             slew_step;
    logic                          slew_unlimited;
  } in_word_t;

  typedef struct packed {
    logic [CHAN_FIELD_W-1:0]       out_channel;
    logic signed [SAMPLE_BITS-1:0] sample_hold_first;
    logic signed [SAMPLE_BITS-1:0] sample_hold_second;
    logic signed [SAMPLE_BITS-1:0] track_hold;
    logic signed [SAMPLE_BITS-1:0] hold_track;
    logic signed [SAMPLE_BITS-1:0] slew_out;
    logic signed [SAMPLE_BITS-1:0] glide_out;
    logic                          gate_active;
  } out_word_t;

  // classified word passed from front to back
  typedef struct packed {
    logic [CHAN_FIELD_W-1:0]       channel;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          on_hit;
    logic                          off_hit;
    logic [STEP_W-1:0]             slew_step;
    logic                          slew_unlimited;
  } work_t;

  function automatic logic signed [SAMPLE_BITS-1:0] limit_toward(
    input logic signed [SAMPLE_BITS-1:0] cur,
    input logic signed [SAMPLE_BITS-1:0] target,
    input logic [STEP_W-1:0]             step,
    input logic                          unlimited
  );
    logic signed [LIM_W-1:0] d;
    logic signed [LIM_W-1:0] lim;
    logic signed [LIM_W-1:0] sum;
    d   = LIM_W'(target) - LIM_W'(cur);
    lim = $signed(LIM_W'(step));
    if (d > lim) d = lim;
    if (d < -lim) d = -lim;
    sum = LIM_W'(cur) + d;
    if (unlimited) return target;
    return SAMPLE_BITS'(sum);
  endfunction

endpackage

@@ hdl/gshs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gshs_front
// Configuration registers and gate threshold classification of input words.
// ----------------------------------------------------------------------------
module gshs_front import gshs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_word,
  output logic                 push_valid,
  input  logic                 push_ready,
  output work_t                push_word,
  output logic [TICK_W-1:0]    glide_delay
);

  logic signed [CFG_W-1:0] gate_on_r;
  logic signed [CFG_W-1:0] gate_off_r;
  logic [TICK_W-1:0]       glide_dly_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_on_r   <= GATE_ON_RST;
      gate_off_r  <= GATE_OFF_RST;
      glide_dly_r <= GLIDE_DLY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GATE_ON:   gate_on_r   <= $signed(cfg_data);
        REG_GATE_OFF:  gate_off_r  <= $signed(cfg_data);
        REG_GLIDE_DLY: glide_dly_r <= TICK_W'(cfg_data);
        default: ;
      endcase
    end
  end

  assign glide_delay = glide_dly_r;
  assign in_ready    = push_ready;
  assign push_valid  = in_valid;

  always_comb begin
    push_word.channel        = in_word.channel;
    push_word.sample_in      = in_word.sample_in;
    push_word.on_hit         = (LIM_W'(in_word.gate_level) >= LIM_W'(gate_on_r)) ||
                               in_word.gate_button;
    push_word.off_hit        = (LIM_W'(in_word.gate_level) <= LIM_W'(gate_off_r)) &&
                               !in_word.gate_button;
    push_word.slew_step      = in_word.slew_step;
    push_word.slew_unlimited = in_word.slew_unlimited;
  end

endmodule

@@ hdl/gshs_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gshs_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module gshs_queue import gshs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_word,
  output logic  pop_valid,
  input  logic  pop_ready,
  output work_t pop_word
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  work_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_word   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_word;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count past depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");

endmodule

@@ hdl/gshs_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gshs_back
// Per-channel gate, hold and slew state update with a registered result word.
// ----------------------------------------------------------------------------
module gshs_back import gshs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  work_t             pop_word,
  input  logic [TICK_W-1:0] glide_delay,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_word
);

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  logic              gate_r       [CHANNELS];
  logic [TICK_W-1:0] ticks_r      [CHANNELS];
  smp_t              sampled1_r   [CHANNELS];
  smp_t              sampled2_r   [CHANNELS];
  smp_t              smooth1_r    [CHANNELS];
  smp_t              smooth2_r    [CHANNELS];
  smp_t              held_r       [CHANNELS];
  smp_t              slew_r       [CHANNELS];
  smp_t              glide_r      [CHANNELS];

  logic              out_valid_r;
  out_word_t         out_word_r;

  logic [CH_W-1:0]   idx;
  logic              take;
  logic              g0, g1, rise, fall;
  smp_t              x, held1, sf1, ss1, tr, ht, slew1, glide1, smf1, sms1;
  logic [TICK_W-1:0] ticks0, ticks1;
  out_word_t         res;

  assign pop_ready = !out_valid_r || out_ready;
  assign take      = pop_valid && pop_ready;

  always_comb begin
    idx    = pop_word.channel[CH_W-1:0];
    x      = pop_word.sample_in;
    g0     = gate_r[idx];
    rise   = !g0 && pop_word.on_hit;
    fall   = g0 && pop_word.off_hit;
    g1     = rise ? 1'b1 : (fall ? 1'b0 : g0);
    held1  = (rise || fall) ? x : held_r[idx];
    sf1    = rise ? x : sampled1_r[idx];
    ss1    = rise ? sampled1_r[idx] : sampled2_r[idx];
    tr     = g1 ? held1 : x;
    ht     = g1 ? x : held1;
    ticks0 = rise ? '0 : ticks_r[idx];
    ticks1 = (g1 && ticks0 != {TICK_W{1'b1}}) ? ticks0 + 1'b1 : ticks0;
    slew1  = g1 ? x : limit_toward(slew_r[idx], x, pop_word.slew_step,
                                   pop_word.slew_unlimited);
    glide1 = (g1 && ticks1 > glide_delay) ?
             limit_toward(glide_r[idx], x, pop_word.slew_step, pop_word.slew_unlimited) : x;
    smf1   = limit_toward(smooth1_r[idx], sf1, pop_word.slew_step, pop_word.slew_unlimited);
    sms1   = limit_toward(smooth2_r[idx], ss1, pop_word.slew_step, pop_word.slew_unlimited);

    res.out_channel        = pop_word.channel;
    res.sample_hold_first  = smf1;
    res.sample_hold_second = sms1;
    res.track_hold         = tr;
    res.hold_track         = ht;
    res.slew_out           = slew1;
    res.glide_out          = glide1;
    res.gate_active        = g1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        gate_r[i]     <= 1'b0;
        ticks_r[i]    <= '0;
        sampled1_r[i] <= '0;
        sampled2_r[i] <= '0;
        smooth1_r[i]  <= '0;
        smooth2_r[i]  <= '0;
        held_r[i]     <= '0;
        slew_r[i]     <= '0;
        glide_r[i]    <= '0;
      end
    end else if (take) begin
      gate_r[idx]     <= g1;
      ticks_r[idx]    <= ticks1;
      sampled1_r[idx] <= sf1;
      sampled2_r[idx] <= ss1;
      smooth1_r[idx]  <= smf1;
      smooth2_r[idx]  <= sms1;
      held_r[idx]     <= held1;
      slew_r[idx]     <= slew1;
      glide_r[idx]    <= glide1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_word_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(take && out_valid_r && !out_ready))
    else $error("result word overwritten while stalled");

  a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid_r)
    else $error("taken word not presented");

  a_gate_on_track: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.gate_active) |->
      (out_word_r.slew_out == out_word_r.hold_track))
    else $error("slew output not following input while gate on");

  a_gate_off_glide: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.gate_active) |->
      (out_word_r.glide_out == out_word_r.track_hold))
    else $error("glide output not following input while gate off");

endmodule

@@ hdl/gated_sample_hold_slew.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_sample_hold_slew
// Per-channel gated sample and hold with slew and glide outputs.
//
// in channel: one word per sample with channel index, signal, gate level,
//   button, slew step and unlimited flag; taken on in_valid and in_ready
// out channel: one result word per input word, in input order
// cfg channel: register index and data, always ready; write only while idle
//   (0 gate on threshold, 1 gate off threshold, 2 glide delay)
// path: an accepted word is written into the queue, then the state update
//   computes its result word into the output register
// throughput: one word per cycle while the output is not stalled, any
//   channel order; each word reads, updates and writes back its channel state
// reset: all channel state cleared, registers back to 6400, 320, 48
// stall: a stalled output holds its word; the two-entry queue keeps
//   taking words until it fills, then in_ready drops
// ----------------------------------------------------------------------------
module gated_sample_hold_slew import gshs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic              push_valid, push_ready;
  work_t             push_word;
  logic              pop_valid, pop_ready;
  work_t             pop_word;
  logic [TICK_W-1:0] glide_delay;

  gshs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word),
    .glide_delay(glide_delay)
  );

  gshs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_word   (pop_word)
  );

  gshs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_word   (pop_word),
    .glide_delay(glide_delay),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

endmodule

@@ verif/slew_hold_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slew_hold_check
// Watches the input, result and register channels of the gated sample and
// hold, keeps its own per-channel copy of the gate, hold and slew state,
// works out the result word for every accepted input word and compares each
// accepted result word with the oldest one still due.
// ----------------------------------------------------------------------------
module slew_hold_check import gshs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_word_t             in_word,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_word_t            out_word,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   pending,
  output int                   checked,
  output int                   rises
);

  logic signed [SAMPLE_BITS-1:0] on_thr;
  logic signed [SAMPLE_BITS-1:0] off_thr;
  logic [TICK_W-1:0]             glide_dly;

  logic                          gate_on  [CHANNELS];
  logic [TICK_W-1:0]             ticks    [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] samp_a   [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] samp_b   [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] smooth_a [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] smooth_b [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] held     [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] slewed   [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] glided   [CHANNELS];

  out_word_t due_words[$];
  int        bad_fields;
  int        n_checked;
  int        n_rises;

  function automatic logic signed [SAMPLE_BITS-1:0] move_toward(
    input logic signed [SAMPLE_BITS-1:0] cur,
    input logic signed [SAMPLE_BITS-1:0] target,
    input logic [STEP_W-1:0]             step,
    input logic                          unl
  );
    int d;
    if (unl) return target;
    d = int'(target) - int'(cur);
    if (d > int'(step)) d = int'(step);
    if (d < -int'(step)) d = -int'(step);
    return SAMPLE_BITS'(int'(cur) + d);
  endfunction

  task automatic report(input string what, input int got, input int want);
    bad_fields++;
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
  endtask

  task automatic advance_channel(input in_word_t w);
    int                            c;
    logic signed [SAMPLE_BITS-1:0] x;
    out_word_t                     r;
    c = w.channel % CHANNELS;
    x = w.sample_in;
    if (!gate_on[c]) begin
      if (w.gate_level >= on_thr || w.gate_button) begin
        gate_on[c] = 1'b1;
        ticks[c]   = '0;
        held[c]    = x;
        samp_b[c]  = samp_a[c];
        samp_a[c]  = x;
        n_rises++;
      end
    end else if (w.gate_level <= off_thr && !w.gate_button) begin
      gate_on[c] = 1'b0;
      held[c]    = x;
    end
    r.track_hold = gate_on[c] ? held[c] : x;
    r.hold_track = gate_on[c] ? x : held[c];
    if (gate_on[c]) begin
      slewed[c] = x;
      if (ticks[c] != '1) ticks[c] = ticks[c] + 1'b1;
    end else begin
      slewed[c] = move_toward(slewed[c], x, w.slew_step, w.slew_unlimited);
    end
    if (gate_on[c] && ticks[c] > glide_dly) begin
      glided[c] = move_toward(glided[c], x, w.slew_step, w.slew_unlimited);
    end else begin
      glided[c] = x;
    end
    smooth_a[c] = move_toward(smooth_a[c], samp_a[c], w.slew_step, w.slew_unlimited);
    smooth_b[c] = move_toward(smooth_b[c], samp_b[c], w.slew_step, w.slew_unlimited);
    r.out_channel        = w.channel;
    r.sample_hold_first  = smooth_a[c];
    r.sample_hold_second = smooth_b[c];
    r.slew_out           = slewed[c];
    r.glide_out          = glided[c];
    r.gate_active        = gate_on[c];
    due_words.push_back(r);
  endtask

  task automatic compare_word(input out_word_t got, input out_word_t want);
    if (got.out_channel !== want.out_channel)
      report("out_channel", int'(got.out_channel), int'(want.out_channel));
    if (got.sample_hold_first !== want.sample_hold_first)
      report("sample_hold_first", int'(got.sample_hold_first), int'(want.sample_hold_first));
    if (got.sample_hold_second !== want.sample_hold_second)
      report("sample_hold_second", int'(got.sample_hold_second),
             int'(want.sample_hold_second));
    if (got.track_hold !== want.track_hold)
      report("track_hold", int'(got.track_hold), int'(want.track_hold));
    if (got.hold_track !== want.hold_track)
      report("hold_track", int'(got.hold_track), int'(want.hold_track));
    if (got.slew_out !== want.slew_out)
      report("slew_out", int'(got.slew_out), int'(want.slew_out));
    if (got.glide_out !== want.glide_out)
      report("glide_out", int'(got.glide_out), int'(want.glide_out));
    if (got.gate_active !== want.gate_active)
      report("gate_active", int'(got.gate_active), int'(want.gate_active));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      on_thr    = GATE_ON_RST;
      off_thr   = GATE_OFF_RST;
      glide_dly = GLIDE_DLY_RST;
      for (int i = 0; i < CHANNELS; i++) begin
        gate_on[i]  = 1'b0;
        ticks[i]    = '0;
        samp_a[i]   = '0;
        samp_b[i]   = '0;
        smooth_a[i] = '0;
        smooth_b[i] = '0;
        held[i]     = '0;
        slewed[i]   = '0;
        glided[i]   = '0;
      end
      due_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          report("unexpected word on channel", int'(out_word.out_channel), -1);
        end else begin
          compare_word(out_word, due_words.pop_front());
          n_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GATE_ON:   on_thr = cfg_data;
          REG_GATE_OFF:  off_thr = cfg_data;
          REG_GLIDE_DLY: glide_dly = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) advance_channel(in_word);
    end
    mismatches <= bad_fields;
    pending    <= due_words.size();
    checked    <= n_checked;
    rises      <= n_rises;
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the gated sample and hold with a directed opening, randomized gate
// bursts under several threshold and glide settings, a long gate-on stretch
// that lets glide engage, and a calm closing stretch;
// the checker beside the block compares every result word.
// ----------------------------------------------------------------------------
module tb;
  import gshs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_word_t             in_word   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  out_word_t            out_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int mismatches;
  int pending;
  int checked;
  int rises;

  bit send_gaps;
  bit recv_stalls;
  int words_sent;
  int settings_used;
  int cur_on;
  int cur_off;

  int on_set  [5] = '{6400, 3200, -500, 32767, -32768};
  int off_set [5] = '{320, -3200, 500, -32768, 32767};
  int dly_set [5] = '{48, 2, 0, 65535, 1};

  gated_sample_hold_slew dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  slew_hold_check check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .rises      (rises)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  always begin
    @(posedge clk);
    if (recv_stalls && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
      out_ready <= 1'b1;
    end
  end

  function automatic in_word_t make_word(input int ch, input int x, input int g,
                                         input bit b, input int step, input bit unl);
    in_word_t w;
    w.channel        = CHAN_FIELD_W'(ch);
    w.sample_in      = SAMPLE_BITS'(x);
    w.gate_level     = SAMPLE_BITS'(g);
    w.gate_button    = b;
    w.slew_step      = STEP_W'(step);
    w.slew_unlimited = unl;
    return w;
  endfunction

  function automatic in_word_t fill_sample(input int ch);
    in_word_t w;
    w = '0;
    w.channel = CHAN_FIELD_W'(ch);
    case ($urandom_range(0, 7))
      0:       w.sample_in = 16'sh7fff;
      1:       w.sample_in = 16'sh8000;
      default: w.sample_in = SAMPLE_BITS'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0, 1:    w.slew_step = STEP_W'($urandom);
      2:       w.slew_step = '0;
      default: w.slew_step = STEP_W'($urandom_range(1, 400));
    endcase
    w.slew_unlimited = ($urandom_range(0, 9) == 0);
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input int gate_on, input int gate_off, input int delay,
                              input bit poke_spare);
    wait_idle();
    cfg_put(REG_GATE_ON, CFG_W'(gate_on));
    cfg_put(REG_GATE_OFF, CFG_W'(gate_off));
    cfg_put(REG_GLIDE_DLY, CFG_W'(delay));
    if (poke_spare) cfg_put(REG_SPARE, 16'h8000);
    cfg_valid <= 1'b0;
    cur_on  = gate_on;
    cur_off = gate_off;
    settings_used++;
  endtask

  // one channel: gate held high for a run, then low for a run, with stray words
  task automatic play_gate_burst();
    int         ch;
    int         on_len;
    int         off_len;
    logic [63:0] raw;
    in_word_t   w;
    ch      = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
    on_len  = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 10);
    off_len = $urandom_range(1, 6);
    for (int i = 0; i < on_len + off_len; i++) begin
      w = fill_sample(ch);
      if (i < on_len) begin
        w.gate_level  = SAMPLE_BITS'(cur_on + int'($urandom_range(0, 32767 - cur_on)));
        w.gate_button = ($urandom_range(0, 5) == 0);
      end else begin
        w.gate_level  = SAMPLE_BITS'(cur_off - int'($urandom_range(0, cur_off + 32768)));
        w.gate_button = 1'b0;
      end
      if ($urandom_range(0, 9) == 0) begin
        raw = {$urandom, $urandom};
        send_word(raw[$bits(in_word_t)-1:0]);
      end
      send_word(w);
    end
  endtask

  initial begin
    in_word_t w;
    int       target;
    cur_on  = int'(GATE_ON_RST);
    cur_off = int'(GATE_OFF_RST);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hysteresis edges, button, full-range steps at reset settings
    send_word(make_word(0, 32767, -32768, 0, 0, 0));
    send_word(make_word(0, -32768, 6400, 0, 65535, 0));
    send_word(make_word(0, 1234, 321, 0, 7, 0));
    send_word(make_word(0, -5, 320, 0, 7, 0));
    send_word(make_word(15, 32767, -32768, 1, 65535, 1));
    send_word(make_word(15, -32768, 6399, 1, 0, 0));
    send_word(make_word(15, 100, 32767, 0, 1, 0));
    send_word(make_word(15, -32768, -32768, 0, 1, 0));
    send_word(make_word(15, 32767, 320, 0, 65535, 0));
    send_word(make_word(7, 0, 6399, 0, 0, 1));

    // overlapping thresholds toggle, glide with zero delay
    program_regs(-100, 100, 0, 1'b1);
    for (int i = 0; i < 4; i++) send_word(make_word(3, $urandom, 0, 0, 50, 0));
    send_word(make_word(5, 2000, 200, 0, 300, 0));
    send_word(make_word(5, -2000, 200, 0, 300, 0));
    send_word(make_word(5, 32767, 101, 0, 65535, 1));

    program_regs(32767, -32768, 65535, 1'b0);
    send_word(make_word(9, 111, 32767, 0, 3, 0));
    send_word(make_word(9, -111, -32767, 0, 3, 0));
    send_word(make_word(9, 0, -32768, 1, 3, 0));
    send_word(make_word(9, 5, -32768, 0, 3, 0));
    send_word(make_word(9, 6, 32766, 0, 3, 0));

    program_regs(-32768, 32767, 1, 1'b0);
    send_word(make_word(12, 400, -32768, 0, 20, 0));
    send_word(make_word(12, -400, 32767, 0, 20, 0));

    for (int p = 0; p < 5; p++) begin
      program_regs(on_set[p], off_set[p], dly_set[p], 1'b0);
      send_gaps   = (p != 1);
      recv_stalls = (p != 2);
      target = words_sent + 65;
      while (words_sent < target) play_gate_burst();
    end

    // gate held on long enough for glide to engage
    program_regs(6400, 320, 30, 1'b0);
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    for (int i = 0; i < 40; i++) begin
      w = fill_sample(6);
      w.gate_level     = 16'sh7fff;
      w.slew_unlimited = 1'b0;
      send_word(w);
    end
    send_word(make_word(6, 0, -32768, 0, 10, 0));

    program_regs(1000, 200, 5, 1'b0);
    target = words_sent + 60;
    while (words_sent < target) play_gate_burst();

    wait_idle();
    repeat (10) @(posedge clk);
    $display("sent %0d input words across %0d register settings, %0d gate rises",
             words_sent, settings_used, rises);
    $display("checked %0d result words, %0d field mismatches", checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
